// ===== rtl/bth_pkg.sv =====
// Shared types and constants for the bounded top-k max-heap.
`timescale 1ns / 1ps

package bth_pkg;

   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] KEEP_RESET = 6'd32;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ROOT_CMP,
      ST_SU_RD,
      ST_SU_CMP,
      ST_SD_RD,
      ST_SD_CMP,
      ST_DR_RD,
      ST_DR_CAP,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_ROOT_RD,
      CMD_SU_START,
      CMD_SU_RD,
      CMD_SU_MOVE,
      CMD_SU_PLACE,
      CMD_EVICT,
      CMD_REJECT,
      CMD_EMPTY,
      CMD_SD_RD,
      CMD_SD_MOVE,
      CMD_SD_PLACE,
      CMD_DR_RD,
      CMD_DR_CAP,
      CMD_EMIT
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_drain;
      logic room;
      logic count_zero;
      logic key_lt_root;
      logic su_at_root;
      logic su_stop;
      logic sd_leaf;
      logic sd_stop;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/bth_ctrl.sv =====
// Sequencer for offer, evict, sift and drain steps of the heap.
`timescale 1ns / 1ps

module bth_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bth_pkg::dp_status_type status,
   output bth_pkg::ctrl_cmd_type  cmd
);

   bth_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bth_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.code  = bth_pkg::CMD_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         bth_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.code = bth_pkg::CMD_LOAD;
               state_in = bth_pkg::ST_DISPATCH;
            end
         end
         bth_pkg::ST_DISPATCH: begin
            if (status.is_drain) begin
               if (status.count_zero) begin
                  cmd.code = bth_pkg::CMD_EMPTY;
                  state_in = bth_pkg::ST_EMIT;
               end else begin
                  state_in = bth_pkg::ST_DR_RD;
               end
            end else if (status.room) begin
               cmd.code = bth_pkg::CMD_SU_START;
               state_in = bth_pkg::ST_SU_RD;
            end else begin
               cmd.code = bth_pkg::CMD_ROOT_RD;
               state_in = bth_pkg::ST_ROOT_CMP;
            end
         end
         bth_pkg::ST_ROOT_CMP: begin
            if (status.key_lt_root) begin
               cmd.code = bth_pkg::CMD_EVICT;
               state_in = bth_pkg::ST_SD_RD;
            end else begin
               cmd.code = bth_pkg::CMD_REJECT;
               state_in = bth_pkg::ST_EMIT;
            end
         end
         bth_pkg::ST_SU_RD: begin
            if (status.su_at_root) begin
               cmd.code = bth_pkg::CMD_SU_PLACE;
               state_in = bth_pkg::ST_EMIT;
            end else begin
               cmd.code = bth_pkg::CMD_SU_RD;
               state_in = bth_pkg::ST_SU_CMP;
            end
         end
         bth_pkg::ST_SU_CMP: begin
            if (status.su_stop) begin
               cmd.code = bth_pkg::CMD_SU_PLACE;
               state_in = bth_pkg::ST_EMIT;
            end else begin
               cmd.code = bth_pkg::CMD_SU_MOVE;
               state_in = bth_pkg::ST_SU_RD;
            end
         end
         bth_pkg::ST_SD_RD: begin
            if (status.sd_leaf) begin
               cmd.code = bth_pkg::CMD_SD_PLACE;
               state_in = status.is_drain ? bth_pkg::ST_DR_RD : bth_pkg::ST_EMIT;
            end else begin
               cmd.code = bth_pkg::CMD_SD_RD;
               state_in = bth_pkg::ST_SD_CMP;
            end
         end
         bth_pkg::ST_SD_CMP: begin
            if (status.sd_stop) begin
               cmd.code = bth_pkg::CMD_SD_PLACE;
               state_in = status.is_drain ? bth_pkg::ST_DR_RD : bth_pkg::ST_EMIT;
            end else begin
               cmd.code = bth_pkg::CMD_SD_MOVE;
               state_in = bth_pkg::ST_SD_RD;
            end
         end
         bth_pkg::ST_DR_RD: begin
            cmd.code = bth_pkg::CMD_DR_RD;
            state_in = bth_pkg::ST_DR_CAP;
         end
         bth_pkg::ST_DR_CAP: begin
            cmd.code = bth_pkg::CMD_DR_CAP;
            state_in = bth_pkg::ST_EMIT;
         end
         bth_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.code = bth_pkg::CMD_EMIT;
               if (status.is_drain && !status.count_zero) begin
                  state_in = bth_pkg::ST_SD_RD;
               end else begin
                  state_in = bth_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = bth_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/bth_datapath.sv =====
// Heap memory, sift registers, compare logic and result register.
`timescale 1ns / 1ps

module bth_datapath #(
   parameter int MAX_KEEP   = 32,
   parameter int INDEX_BITS = 24,
   parameter int DIST_BITS  = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bth_pkg::ctrl_cmd_type       cmd,
   output bth_pkg::dp_status_type      status,
   input  logic                        req_operation,
   input  logic [DIST_BITS-1:0]        req_distance,
   input  logic [INDEX_BITS-1:0]       req_point_index,
   input  logic                        csr_wr_en,
   input  logic [bth_pkg::CNT_W-1:0]   csr_wr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_result_valid,
   output logic [DIST_BITS-1:0]        rsp_out_distance,
   output logic [INDEX_BITS-1:0]       rsp_out_index,
   output logic                        rsp_accepted,
   output logic [bth_pkg::CNT_W-1:0]   rsp_held_count,
   output logic                        rsp_last
);

   localparam int KW  = DIST_BITS + INDEX_BITS;
   localparam int AW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CW  = $clog2(MAX_KEEP + 1);
   localparam int CHW = $clog2(2 * MAX_KEEP + 1);

   logic [KW-1:0] heap_ff [MAX_KEEP];
   logic [KW-1:0] rd_a_ff, rd_b_ff;

   logic                      op_ff, op_in;
   logic [KW-1:0]             v_ff, v_in;
   logic [KW-1:0]             old_ff, old_in;
   logic [AW-1:0]             cur_ff, cur_in;
   logic [CW-1:0]             n_ff, n_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [bth_pkg::CNT_W-1:0] keep_ff;
   logic                      res_valid_ff, res_valid_in;
   logic                      res_acc_ff, res_acc_in;

   logic                      rsp_valid_ff;
   logic                      rsp_result_valid_ff;
   logic [DIST_BITS-1:0]      rsp_out_distance_ff;
   logic [INDEX_BITS-1:0]     rsp_out_index_ff;
   logic                      rsp_accepted_ff;
   logic [bth_pkg::CNT_W-1:0] rsp_held_count_ff;
   logic                      rsp_last_ff;

   logic [CHW-1:0] child, child_p1, n_ext;
   logic [AW-1:0]  parent, last_addr;
   logic [CW-1:0]  lim;
   logic           use_right;
   logic [KW-1:0]  chosen;
   logic [AW-1:0]  chosen_addr;
   logic           rd_en, wr_en;
   logic [AW-1:0]  addr_a, addr_b, wr_addr;
   logic [KW-1:0]  wr_data;
   logic           out_free;

   assign child     = ({{(CHW-AW){1'b0}}, cur_ff} << 1) + CHW'(1);
   assign child_p1  = child + CHW'(1);
   assign n_ext     = {{(CHW-CW){1'b0}}, n_ff};
   assign parent    = (cur_ff - AW'(1)) >> 1;
   assign last_addr = AW'(count_ff - CW'(1));
   assign use_right = (child_p1 < n_ext) && (rd_a_ff < rd_b_ff);
   assign chosen    = use_right ? rd_b_ff : rd_a_ff;
   assign chosen_addr = use_right ? child_p1[AW-1:0] : child[AW-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (keep_ff == '0) begin
         lim = CW'(1);
      end else if ({1'b0, keep_ff} > (bth_pkg::CNT_W+1)'(MAX_KEEP)) begin
         lim = CW'(MAX_KEEP);
      end else begin
         lim = CW'(keep_ff);
      end
   end

   always_comb begin
      status.is_drain    = (op_ff == bth_pkg::OP_DRAIN);
      status.room        = (count_ff < lim);
      status.count_zero  = (count_ff == '0);
      status.key_lt_root = (v_ff < rd_a_ff);
      status.su_at_root  = (cur_ff == '0);
      status.su_stop     = !(rd_a_ff < v_ff);
      status.sd_leaf     = (child >= n_ext);
      status.sd_stop     = (chosen <= v_ff);
      status.out_free    = out_free;
   end

   always_comb begin
      op_in        = op_ff;
      v_in         = v_ff;
      old_in       = old_ff;
      cur_in       = cur_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      res_valid_in = res_valid_ff;
      res_acc_in   = res_acc_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      addr_a       = '0;
      addr_b       = '0;
      wr_addr      = cur_ff;
      wr_data      = v_ff;
      unique case (cmd.code) inside
         bth_pkg::CMD_LOAD: begin
            op_in = req_operation;
            v_in  = {req_distance, req_point_index};
         end
         bth_pkg::CMD_ROOT_RD: begin
            rd_en = 1'b1;
         end
         bth_pkg::CMD_SU_START: begin
            cur_in       = AW'(count_ff);
            count_in     = count_ff + CW'(1);
            res_valid_in = 1'b0;
            res_acc_in   = 1'b1;
         end
         bth_pkg::CMD_SU_RD: begin
            rd_en  = 1'b1;
            addr_a = parent;
         end
         bth_pkg::CMD_SU_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_a_ff;
            cur_in  = parent;
         end
         bth_pkg::CMD_SU_PLACE, bth_pkg::CMD_SD_PLACE: begin
            wr_en = 1'b1;
         end
         bth_pkg::CMD_EVICT: begin
            old_in       = rd_a_ff;
            cur_in       = '0;
            n_in         = count_ff;
            res_valid_in = 1'b1;
            res_acc_in   = 1'b1;
         end
         bth_pkg::CMD_REJECT, bth_pkg::CMD_EMPTY: begin
            res_valid_in = 1'b0;
            res_acc_in   = 1'b0;
         end
         bth_pkg::CMD_SD_RD: begin
            rd_en  = 1'b1;
            addr_a = child[AW-1:0];
            addr_b = child_p1[AW-1:0];
         end
         bth_pkg::CMD_SD_MOVE: begin
            wr_en   = 1'b1;
            wr_data = chosen;
            cur_in  = chosen_addr;
         end
         bth_pkg::CMD_DR_RD: begin
            rd_en  = 1'b1;
            addr_b = last_addr;
         end
         bth_pkg::CMD_DR_CAP: begin
            old_in       = rd_a_ff;
            v_in         = rd_b_ff;
            count_in     = count_ff - CW'(1);
            n_in         = count_ff - CW'(1);
            cur_in       = '0;
            res_valid_in = 1'b1;
            res_acc_in   = 1'b0;
         end
         bth_pkg::CMD_NONE, bth_pkg::CMD_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // heap memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= heap_ff[addr_a];
         rd_b_ff <= heap_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         keep_ff      <= bth_pkg::KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            keep_ff <= csr_wr_data;
         end
         if (cmd.code == bth_pkg::CMD_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      v_ff         <= v_in;
      old_ff       <= old_in;
      cur_ff       <= cur_in;
      n_ff         <= n_in;
      res_valid_ff <= res_valid_in;
      res_acc_ff   <= res_acc_in;
      if (cmd.code == bth_pkg::CMD_EMIT) begin
         rsp_result_valid_ff <= res_valid_ff;
         rsp_out_distance_ff <= res_valid_ff ? old_ff[KW-1:INDEX_BITS] : '0;
         rsp_out_index_ff    <= res_valid_ff ? old_ff[INDEX_BITS-1:0] : '0;
         rsp_accepted_ff     <= res_acc_ff;
         rsp_held_count_ff   <= bth_pkg::CNT_W'(count_ff);
         rsp_last_ff         <= (op_ff != bth_pkg::OP_DRAIN) || (count_ff == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_valid = rsp_result_valid_ff;
   assign rsp_out_distance = rsp_out_distance_ff;
   assign rsp_out_index    = rsp_out_index_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_held_count   = rsp_held_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/bounded_topk_max_heap.sv =====
// Offer: sift up into a free slot, or compare to the root, then evict and sift down or reject.
// Drain: if empty, one word without result; else one word per entry, largest first.
// Sift steps are set by one heap memory access (registered read) and compare per level.
// One input word is worked at a time; the next is taken the cycle after its last result is loaded.
// Reset (synchronous): heap empty, keep_count 32, no result pending; heap memory is not cleared.
`timescale 1ns / 1ps

module bounded_topk_max_heap #(
   parameter int MAX_KEEP   = 32,
   parameter int INDEX_BITS = 24,
   parameter int DIST_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [DIST_BITS-1:0]      req_distance,
   input  logic [INDEX_BITS-1:0]     req_point_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_result_valid,
   output logic [DIST_BITS-1:0]      rsp_out_distance,
   output logic [INDEX_BITS-1:0]     rsp_out_index,
   output logic                      rsp_accepted,
   output logic [bth_pkg::CNT_W-1:0] rsp_held_count,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [bth_pkg::CNT_W-1:0] csr_wr_data
);

   bth_pkg::ctrl_cmd_type  cmd;
   bth_pkg::dp_status_type status;

   bth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bth_datapath #(
      .MAX_KEEP   (MAX_KEEP),
      .INDEX_BITS (INDEX_BITS),
      .DIST_BITS  (DIST_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_distance     (req_distance),
      .req_point_index  (req_point_index),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_valid (rsp_result_valid),
      .rsp_out_distance (rsp_out_distance),
      .rsp_out_index    (rsp_out_index),
      .rsp_accepted     (rsp_accepted),
      .rsp_held_count   (rsp_held_count),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== test/topk_heap_checker.sv =====
// Checker for the bounded top-k max-heap: predicts result words and compares them.
`timescale 1ns / 1ps

module topk_heap_checker #(
   parameter int MAX_KEEP   = 32,
   parameter int INDEX_BITS = 24,
   parameter int DIST_BITS  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_operation,
   input  logic [DIST_BITS-1:0]      req_distance,
   input  logic [INDEX_BITS-1:0]     req_point_index,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_result_valid,
   input  logic [DIST_BITS-1:0]      rsp_out_distance,
   input  logic [INDEX_BITS-1:0]     rsp_out_index,
   input  logic                      rsp_accepted,
   input  logic [bth_pkg::CNT_W-1:0] rsp_held_count,
   input  logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [bth_pkg::CNT_W-1:0] csr_wr_data,
   output int                        mismatches,
   output int                        pending
);

   localparam int KEY_W = DIST_BITS + INDEX_BITS;
   localparam int CNT_W = bth_pkg::CNT_W;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct {
      logic                  pair_valid;
      logic [DIST_BITS-1:0]  distance;
      logic [INDEX_BITS-1:0] idx;
      logic                  accepted;
      logic [CNT_W-1:0]      held;
      logic                  last;
   } heap_word_type;

   key_type          heap_keys [MAX_KEEP];
   int unsigned      fill;
   logic [CNT_W-1:0] keep_reg;
   heap_word_type    expected_words [$];

   function automatic int unsigned keep_limit();
      if (keep_reg == 0) return 1;
      if (keep_reg > MAX_KEEP) return MAX_KEEP;
      return 32'(keep_reg);
   endfunction

   function automatic void raise_key(int unsigned pos, key_type k);
      int unsigned cur;
      int unsigned up;
      cur = pos;
      while (cur > 0) begin
         up = (cur - 1) >> 1;
         if (heap_keys[up] < k) begin
            heap_keys[cur] = heap_keys[up];
            cur = up;
         end else begin
            break;
         end
      end
      heap_keys[cur] = k;
   endfunction

   function automatic void settle_from_root(int unsigned n, key_type k);
      int unsigned cur;
      int unsigned child;
      bit          done;
      cur  = 0;
      done = 1'b0;
      while (!done) begin
         child = 2 * cur + 1;
         if (child >= n) begin
            done = 1'b1;
         end else begin
            if (child + 1 < n && heap_keys[child] < heap_keys[child + 1]) child++;
            if (heap_keys[child] <= k) begin
               done = 1'b1;
            end else begin
               heap_keys[cur] = heap_keys[child];
               cur = child;
            end
         end
      end
      if (n > 0) heap_keys[cur] = k;
   endfunction

   function automatic heap_word_type make_word(logic v, key_type k, logic acc,
                                               int unsigned held, logic last);
      heap_word_type w;
      w.pair_valid = v;
      w.distance   = v ? k[KEY_W-1:INDEX_BITS] : '0;
      w.idx        = v ? k[INDEX_BITS-1:0] : '0;
      w.accepted   = acc;
      w.held       = CNT_W'(held);
      w.last       = last;
      return w;
   endfunction

   function automatic void predict_word(logic op, logic [DIST_BITS-1:0] d,
                                        logic [INDEX_BITS-1:0] i);
      key_type k;
      key_type top;
      k = {d, i};
      if (op == bth_pkg::OP_OFFER) begin
         if (fill < keep_limit()) begin
            raise_key(fill, k);
            fill++;
            expected_words.push_back(make_word(1'b0, '0, 1'b1, fill, 1'b1));
         end else if (k < heap_keys[0]) begin
            top = heap_keys[0];
            settle_from_root(fill, k);
            expected_words.push_back(make_word(1'b1, top, 1'b1, fill, 1'b1));
         end else begin
            expected_words.push_back(make_word(1'b0, '0, 1'b0, fill, 1'b1));
         end
      end else if (fill == 0) begin
         expected_words.push_back(make_word(1'b0, '0, 1'b0, 0, 1'b1));
      end else begin
         while (fill > 0) begin
            top = heap_keys[0];
            fill--;
            if (fill > 0) settle_from_root(fill, heap_keys[fill]);
            expected_words.push_back(make_word(1'b1, top, 1'b0, fill, fill == 0));
         end
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      heap_word_type want;
      if (reset) begin
         fill       = 0;
         keep_reg   = bth_pkg::KEEP_RESET;
         mismatches = 0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) keep_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word, distance", 64'(rsp_out_distance), 64'(0));
            end else begin
               want = expected_words.pop_front();
               if (rsp_result_valid !== want.pair_valid)
                  report_mismatch("result_valid", 64'(rsp_result_valid),
                                  64'(want.pair_valid));
               if (rsp_out_distance !== want.distance)
                  report_mismatch("out_distance", 64'(rsp_out_distance),
                                  64'(want.distance));
               if (rsp_out_index !== want.idx)
                  report_mismatch("out_index", 64'(rsp_out_index), 64'(want.idx));
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", 64'(rsp_accepted), 64'(want.accepted));
               if (rsp_held_count !== want.held)
                  report_mismatch("held_count", 64'(rsp_held_count), 64'(want.held));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (req_valid && !req_stall)
            predict_word(req_operation, req_distance, req_point_index);
      end
      pending <= expected_words.size();
   end

endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, keep_count writes and offer/drain traffic for the heap.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_KEEP      = 32;
   localparam int INDEX_BITS    = 24;
   localparam int DIST_BITS     = 32;
   localparam int CNT_W         = bth_pkg::CNT_W;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_WORDS  = 235;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic                  req_operation   = bth_pkg::OP_OFFER;
   logic [DIST_BITS-1:0]  req_distance    = '0;
   logic [INDEX_BITS-1:0] req_point_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic                  rsp_result_valid;
   logic [DIST_BITS-1:0]  rsp_out_distance;
   logic [INDEX_BITS-1:0] rsp_out_index;
   logic                  rsp_accepted;
   logic [CNT_W-1:0]      rsp_held_count;
   logic                  rsp_last;
   logic                  csr_wr_en       = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data     = '0;

   int          mismatches;
   int          pending;
   logic        calm        = 1'b0;
   int unsigned rsp_wait    = 0;
   int unsigned idle_cycles = 0;
   int unsigned words_sent  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bounded_topk_max_heap #(
      .MAX_KEEP(MAX_KEEP), .INDEX_BITS(INDEX_BITS), .DIST_BITS(DIST_BITS)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_distance(req_distance), .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_valid(rsp_result_valid),
      .rsp_out_distance(rsp_out_distance), .rsp_out_index(rsp_out_index),
      .rsp_accepted(rsp_accepted), .rsp_held_count(rsp_held_count), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   topk_heap_checker #(
      .MAX_KEEP(MAX_KEEP), .INDEX_BITS(INDEX_BITS), .DIST_BITS(DIST_BITS)
   ) u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_operation(req_operation),
      .req_distance(req_distance), .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_valid(rsp_result_valid),
      .rsp_out_distance(rsp_out_distance), .rsp_out_index(rsp_out_index),
      .rsp_accepted(rsp_accepted), .rsp_held_count(rsp_held_count), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .mismatches(mismatches), .pending(pending)
   );

   function automatic int unsigned draw_gap(logic quiet);
      if (quiet || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [DIST_BITS-1:0] pick_distance();
      case ($urandom_range(0, 3))
         0: return DIST_BITS'($urandom_range(0, 7));
         1: return '1 - DIST_BITS'($urandom_range(0, 3));
         default: return DIST_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [INDEX_BITS-1:0] pick_index();
      case ($urandom_range(0, 3))
         0: return INDEX_BITS'($urandom_range(0, 3));
         1: return '1 - INDEX_BITS'($urandom_range(0, 3));
         default: return INDEX_BITS'($urandom());
      endcase
   endfunction

   // result side stall: a fresh hold-off is drawn after every accepted word
   always @(posedge clock) begin : rsp_side
      int unsigned w;
      w = draw_gap(calm);
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait  <= w;
         rsp_stall <= (w != 0);
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait  <= 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("bounded_topk_max_heap: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(logic op, logic [DIST_BITS-1:0] d, logic [INDEX_BITS-1:0] i);
      int unsigned gap;
      gap = draw_gap(calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_distance    <= d;
      req_point_index <= i;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic offer(logic [DIST_BITS-1:0] d, logic [INDEX_BITS-1:0] i);
      send_word(bth_pkg::OP_OFFER, d, i);
   endtask

   task automatic drain();
      send_word(bth_pkg::OP_DRAIN, DIST_BITS'($urandom()), INDEX_BITS'($urandom()));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(logic [CNT_W-1:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned      target;
      int unsigned      n;
      logic [CNT_W-1:0] keep;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty drain, field extremes, duplicate key
      drain();
      offer('0, '0);
      offer('1, '1);
      offer('1, '0);
      offer('0, '1);
      offer('1, '1);
      drain();
      // keep 1: eviction, equal key and larger index rejected, index tie break
      write_keep(CNT_W'(1));
      offer(DIST_BITS'(100), INDEX_BITS'(5));
      offer(DIST_BITS'(50), INDEX_BITS'(7));
      offer(DIST_BITS'(50), INDEX_BITS'(7));
      offer(DIST_BITS'(50), INDEX_BITS'(8));
      offer(DIST_BITS'(50), INDEX_BITS'(6));
      drain();
      // zero acts as one
      write_keep(CNT_W'(0));
      offer(DIST_BITS'(9), INDEX_BITS'(9));
      offer(DIST_BITS'(3), INDEX_BITS'(3));
      drain();
      // above the maximum acts as the maximum, then lower the limit under the fill
      write_keep('1);
      repeat (5) offer(pick_distance(), pick_index());
      write_keep(CNT_W'(2));
      offer('0, '0);
      offer('1, '1);
      drain();

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         calm <= ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 5))
            0: keep = CNT_W'(1);
            1: keep = CNT_W'(MAX_KEEP);
            2: keep = $urandom_range(0, 1) ? '0 : '1;
            3: keep = CNT_W'($urandom_range(1, MAX_KEEP));
            default: keep = CNT_W'($urandom_range(2, 8));
         endcase
         if ($urandom_range(0, 2) != 0) write_keep(keep);
         n = $urandom_range(1, 24);
         repeat (n) begin
            if ($urandom_range(0, 24) == 0) drain();
            else offer(pick_distance(), pick_index());
         end
         if ($urandom_range(0, 3) != 0) drain();
         if ($urandom_range(0, 5) == 0) drain();
      end

      wait_idle();
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("bounded_topk_max_heap: match");
      end else begin
         $display("bounded_topk_max_heap: mismatch");
      end
      $finish;
   end

endmodule
